[rtl/fbh_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and the FNV-1a byte step for the bucket hash block.
// No dependencies; compile first.
package fbh_pkg;

  localparam int HASH_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 25;
  localparam int IDX_W     = 24;
  localparam int CFG_W     = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int STEP_W    = $clog2(HASH_W);

  localparam logic [HASH_W-1:0]  FNV_BASIS   = 32'd2166136261;
  localparam logic [HASH_W-1:0]  FNV_PRIME   = 32'd16777619;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 25'd256;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 25'd16777216;
  localparam logic [COUNT_W-1:0] COUNT_MIN   = 25'd1;

  // Register index as decoded from the word address
  localparam logic REG_BUCKET_COUNT = 1'b0;

  // Fold one byte in, then multiply by the prime (2^24 + 403) as shift-adds.
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] hash,
                                                 input logic [BYTE_W-1:0] key_byte);
    logic [HASH_W-1:0] x;
    x = hash ^ {{(HASH_W-BYTE_W){1'b0}}, key_byte};
    return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
  endfunction

endpackage

[rtl/fbh_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for key bytes and bucket results.
// Depends on fbh_pkg.
interface fbh_in_if import fbh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] key_byte;
  logic              has_byte;
  logic              end_of_key;

  modport source (output valid, key_byte, has_byte, end_of_key, input ready);
  modport sink   (input valid, key_byte, has_byte, end_of_key, output ready);
endinterface

interface fbh_out_if import fbh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] bucket_index;

  modport source (output valid, bucket_index, input ready);
  modport sink   (input valid, bucket_index, output ready);
endinterface

[rtl/fbh_cfg.sv]
`timescale 1ns / 1ps
// APB register bank holding the bucket count and its clamped divisor form.
// Depends on fbh_pkg.
module fbh_cfg import fbh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]      pwdata,
  output logic [CFG_W-1:0]      prdata,
  output logic                  pready,
  output logic [COUNT_W-1:0]    divisor
);

  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic               reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready && (reg_idx == REG_BUCKET_COUNT);

  always_comb begin
    count_nxt = count_r;
    if (wr_en) begin
      count_nxt = pwdata[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_BUCKET_COUNT) begin
      prdata = {{(CFG_W-COUNT_W){1'b0}}, count_r};
    end
  end

  // Zero counts as one bucket; anything above 2^24 is held at 2^24
  always_comb begin
    divisor = count_r;
    if (count_r == '0) begin
      divisor = COUNT_MIN;
    end else if (count_r > COUNT_MAX) begin
      divisor = COUNT_MAX;
    end
  end

endmodule

[rtl/fbh_divider.sv]
`timescale 1ns / 1ps
// Restoring remainder unit: one dividend bit per cycle.
// Depends on fbh_pkg.
module fbh_divider import fbh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [HASH_W-1:0]  dividend,
  input  logic [COUNT_W-1:0] divisor,
  output logic               busy,
  output logic               done,
  output logic [IDX_W-1:0]   remainder
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [HASH_W-1:0]  dvd_r, dvd_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [COUNT_W-1:0] dvs_r, dvs_nxt;
  logic [COUNT_W-1:0] trial;

  // Remainder stays below the divisor (at most 2^24), so its top bit is clear
  assign trial = {rem_r[COUNT_W-2:0], dvd_r[HASH_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      rem_nxt = (trial >= dvs_r) ? trial - dvs_r : trial;
      cnt_nxt = cnt_r + STEP_W'(1);
      if (cnt_r == STEP_W'(HASH_W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign remainder = rem_r[IDX_W-1:0];

  a_done_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_r))
    else $error("remainder not below divisor at completion");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider not busy after start");

  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("done without a finished divide");

endmodule

[rtl/fnv1a_bucket_hash_top.sv]
`timescale 1ns / 1ps
// FNV-1a bucket hash: top level with sequencer, hash register and result register.
// Depends on fbh_pkg, fbh_if, fbh_cfg and fbh_divider.
//
// Feed a key one request at a time on in_ch: each request carrying a byte
// (has_byte high) folds it into a running 32-bit FNV-1a hash, so byte
// requests stream at one per clock while the sequencer is idle. A request
// with end_of_key high folds in its byte if it carries one, then hands the
// hash to a restoring remainder unit that works one bit per cycle against
// the bucket count; the input stays not-ready for that time, and the next
// request is taken at the earliest once the remainder steps are done, the
// sequencer has seen the unit finish and the result register is loaded. The
// running hash returns to the offset basis as soon as the end request is
// taken. The bucket index lands in an output register on out_ch and waits
// there for the sink; the input reopens as soon as it is loaded. A request
// with neither byte nor end mark is taken and dropped. The bucket count
// register (byte address 0, 25 bits, reset 256) is read and written over the
// APB-style cfg_ port; a count of zero acts as one bucket and counts above
// 2^24 act as 2^24. Write it only while no key is in flight.
module fnv1a_bucket_hash_top import fbh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  fbh_in_if.sink                in_ch,
  fbh_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_W-1:0]      cfg_pwdata,
  output logic [CFG_W-1:0]      cfg_prdata,
  output logic                  cfg_pready
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [HASH_W-1:0]  hash_r, hash_nxt;
  logic [HASH_W-1:0]  mixed;
  logic               out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic               in_acc;
  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [IDX_W-1:0]   div_rem;
  logic [COUNT_W-1:0] divisor;
  logic               out_free;

  fbh_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .divisor (divisor)
  );

  // Take requests only while the sequencer is idle
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign div_start   = in_acc && in_ch.end_of_key;

  // Fold the request byte in, or hold the hash when there is none
  assign mixed = in_ch.has_byte ? fnv_step(hash_r, in_ch.key_byte) : hash_r;

  fbh_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mixed),
    .divisor   (divisor),
    .busy      (div_busy),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_idx_nxt   = out_idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          hash_nxt = mixed;
          if (in_ch.end_of_key) begin
            // Hash is in the divider now; start the next key afresh
            hash_nxt  = FNV_BASIS;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the remainder until the result register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = div_rem;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hash_r      <= FNV_BASIS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r <= out_idx_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.bucket_index = out_idx_r;

  a_end_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !in_ch.ready && div_busy)
    else $error("input still open after end of key");

  a_hash_rebased: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (hash_r == FNV_BASIS))
    else $error("running hash not returned to basis");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared without a finished divide");

  a_no_input_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> !in_ch.ready)
    else $error("input open while divider busy");

endmodule
